// File: sv/clp_pkg.sv
// Shared constants for the carrot lookahead point generator.
package clp_pkg;

   // field widths
   localparam int COORD_W = 24;
   localparam int DIST_W  = 23;
   localparam int COUNT_W = 9;
   localparam int INDEX_W = 8;

   // default sizes
   localparam int MAX_POINTS_DEF   = 256;
   localparam int BACK_WINDOW_DEF  = 5;
   localparam int AHEAD_WINDOW_DEF = 20;

   // register indexes
   localparam logic [2:0] CSR_LOOKAHEAD = 3'd0;
   localparam logic [2:0] CSR_MAX_JUMP  = 3'd1;
   localparam logic [2:0] CSR_COUNT     = 3'd2;
   localparam logic [2:0] CSR_REACH     = 3'd3;
   localparam logic [2:0] CSR_FINISH    = 3'd4;

   // register reset values
   localparam logic [DIST_W-1:0]  LOOKAHEAD_RST = 23'd19661;
   localparam logic [DIST_W-1:0]  MAX_JUMP_RST  = 23'd21299;
   localparam logic [COUNT_W-1:0] COUNT_RST     = 9'd2;
   localparam logic [DIST_W-1:0]  REACH_RST     = 23'd9830;
   localparam logic [DIST_W-1:0]  FINISH_RST    = 23'd6554;

   // action codes
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_START  = 2'd1;
   localparam logic [1:0] ACT_UPDATE = 2'd2;

endpackage

// File: sv/carrot_lookahead_point.sv
// Carrot lookahead point generator: waypoint store, sequencer and shared arithmetic unit.
//
// Usage: items enter on the req_ channel (valid/ready). A load item writes one
// waypoint slot, a start item clears the phase flags; neither gives a result.
// A position update gives one rsp_ item: the carrot point, layer_done and
// following. Registers are written on the csr_ port (write enable, index,
// data) by the user only while the block is idle; the block does not enforce it.
// Load and start items leave the block idle. An update runs through one shared
// multiplier, a bit-serial square root (25 steps) and a restoring divider
// (48 steps) under the sequencer: a distance for each window point searched,
// each segment walked and the jump and finish tests, then a multiply and divide
// per axis for the interpolation; a lead-in update takes one distance.
// One item is in work at a time; req_ready is high only while idle.
// The result sits in an output register, so the next item is taken while a
// stalled result waits; a second update waits at its end for the register.
// Reset (synchronous, active high) clears flags, previous carrot and the
// registers to their defaults; waypoint contents are kept and undefined
// until loaded.
module carrot_lookahead_point #(
   parameter int MAX_POINTS   = clp_pkg::MAX_POINTS_DEF,
   parameter int BACK_WINDOW  = clp_pkg::BACK_WINDOW_DEF,
   parameter int AHEAD_WINDOW = clp_pkg::AHEAD_WINDOW_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_action,
   input  logic [clp_pkg::INDEX_W-1:0]         req_point_index,
   input  logic signed [clp_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [clp_pkg::COORD_W-1:0]  req_coord_y,
   input  logic signed [clp_pkg::COORD_W-1:0]  req_coord_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [clp_pkg::COORD_W-1:0]  rsp_carrot_x,
   output logic signed [clp_pkg::COORD_W-1:0]  rsp_carrot_y,
   output logic signed [clp_pkg::COORD_W-1:0]  rsp_carrot_z,
   output logic                                rsp_layer_done,
   output logic                                rsp_following,
   input  logic                                csr_we,
   input  logic [2:0]                          csr_index,
   input  logic [clp_pkg::DIST_W-1:0]          csr_wdata
);
   import clp_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = AW + 1;
   localparam int WW = 3 * COORD_W;

   // sequencer states
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_RDW   = 5'd1;
   localparam logic [4:0] S_DSUB  = 5'd2;
   localparam logic [4:0] S_DMUL  = 5'd3;
   localparam logic [4:0] S_DSQ   = 5'd4;
   localparam logic [4:0] S_LEAD  = 5'd5;
   localparam logic [4:0] S_LEAD2 = 5'd6;
   localparam logic [4:0] S_WIN   = 5'd7;
   localparam logic [4:0] S_WIN2  = 5'd8;
   localparam logic [4:0] S_WIN3  = 5'd9;
   localparam logic [4:0] S_WALK  = 5'd10;
   localparam logic [4:0] S_WALK1 = 5'd11;
   localparam logic [4:0] S_WALK2 = 5'd12;
   localparam logic [4:0] S_WALK3 = 5'd13;
   localparam logic [4:0] S_ISUB  = 5'd14;
   localparam logic [4:0] S_IMUL  = 5'd15;
   localparam logic [4:0] S_IDIV  = 5'd16;
   localparam logic [4:0] S_IFIN  = 5'd17;
   localparam logic [4:0] S_LAST  = 5'd18;
   localparam logic [4:0] S_LAST2 = 5'd19;
   localparam logic [4:0] S_JUMP  = 5'd20;
   localparam logic [4:0] S_JUMP2 = 5'd21;
   localparam logic [4:0] S_FIN0  = 5'd22;
   localparam logic [4:0] S_FIN1  = 5'd23;
   localparam logic [4:0] S_FIN2  = 5'd24;
   localparam logic [4:0] S_OUT   = 5'd25;

   // configuration
   logic [DIST_W-1:0]  lookahead_ff, max_jump_ff, reach_ff, finish_ff;
   logic [COUNT_W-1:0] count_ff;

   // control
   logic [4:0]    state_ff, ret_ff, dret_ff;
   logic          first_ff, cvalid_ff, near_ff, done_ff, have_ff, neg_ff;
   logic [AW-1:0] lc_ff, addr_ff;
   logic [CW-1:0] n_ff, i_ff, end_ff, j_ff, closest_ff;
   logic [1:0]    axis_ff;
   logic [5:0]    cnt_ff;

   // datapath
   logic [WW-1:0]              mem [MAX_POINTS];
   logic [WW-1:0]              rd_ff;
   logic signed [COORD_W-1:0]  pos_ff [3];
   logic signed [COORD_W-1:0]  op_a_ff [3];
   logic signed [COORD_W-1:0]  op_b_ff [3];
   logic signed [COORD_W-1:0]  carrot_ff [3];
   logic signed [COORD_W-1:0]  prev_ff [3];
   logic [24:0]                mag_ff, root_ff, best_ff, drem_ff;
   logic [49:0]                acc_ff, rad_ff;
   logic [25:0]                sq_rem_ff;
   logic [47:0]                dnum_ff;
   logic [DIST_W-1:0]          rem_ff;

   // output register
   logic                       rsp_valid_ff, rsp_done_ff, rsp_follow_ff;
   logic signed [COORD_W-1:0]  rsp_x_ff, rsp_y_ff, rsp_z_ff;

   logic accept, mem_we;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign mem_we    = accept && (req_action == ACT_LOAD) &&
                      (32'(req_point_index) < MAX_POINTS);

   // layer size saturated to at least two and at most the store depth
   logic [CW-1:0] n_sat, win_start, win_end;
   always_comb begin
      if (count_ff < 9'd2) n_sat = CW'(2);
      else if (32'(count_ff) > MAX_POINTS) n_sat = CW'(MAX_POINTS);
      else n_sat = CW'(count_ff);
   end

   // search window around the previous closest point
   always_comb begin
      if (32'(lc_ff) > BACK_WINDOW) win_start = CW'(32'(lc_ff) - BACK_WINDOW);
      else win_start = '0;
      if (32'(lc_ff) + AHEAD_WINDOW > 32'(n_sat) - 1) win_end = n_sat - CW'(1);
      else win_end = CW'(32'(lc_ff) + AHEAD_WINDOW);
   end

   // per-axis difference of the operand registers
   logic signed [24:0] diff;
   logic [24:0]        mag;
   assign diff = {op_a_ff[axis_ff][COORD_W-1], op_a_ff[axis_ff]} -
                 {op_b_ff[axis_ff][COORD_W-1], op_b_ff[axis_ff]};
   assign mag  = diff[24] ? 25'(-diff) : 25'(diff);

   // shared multiplier: squares for distances, remaining lookahead times delta for interpolation
   logic [24:0] mul_a;
   logic [49:0] prod;
   assign mul_a = (state_ff == S_DMUL) ? mag_ff : {2'b00, rem_ff};
   assign prod  = 50'(mul_a) * 50'(mag_ff);

   // one square root step, two radicand bits at a time
   logic [27:0] sq_r2, sq_trial;
   logic        sq_take;
   assign sq_r2    = {sq_rem_ff, rad_ff[49:48]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_take  = (sq_r2 >= sq_trial);

   // one restoring divide step
   logic [25:0] dv_t, dv_d;
   logic        dv_take;
   assign dv_t    = {drem_ff, dnum_ff[47]};
   assign dv_d    = {1'b0, root_ff};
   assign dv_take = (dv_t >= dv_d);

   // floor quotient and interpolated coordinate
   logic signed [25:0] quot;
   logic signed [25:0] interp;
   always_comb begin
      if (neg_ff) quot = -($signed({1'b0, dnum_ff[24:0]}) + 26'(drem_ff != '0));
      else quot = $signed({1'b0, dnum_ff[24:0]});
      interp = 26'(op_b_ff[axis_ff]) + quot;
   end

   // waypoint store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(req_point_index)] <= {req_coord_z, req_coord_y, req_coord_x};
      end
      rd_ff <= mem[addr_ff];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lookahead_ff <= LOOKAHEAD_RST;
         max_jump_ff  <= MAX_JUMP_RST;
         count_ff     <= COUNT_RST;
         reach_ff     <= REACH_RST;
         finish_ff    <= FINISH_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOOKAHEAD: lookahead_ff <= csr_wdata;
            CSR_MAX_JUMP:  max_jump_ff  <= csr_wdata;
            CSR_COUNT:     count_ff     <= csr_wdata[COUNT_W-1:0];
            CSR_REACH:     reach_ff     <= csr_wdata;
            CSR_FINISH:    finish_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= 1'b0;
         cvalid_ff    <= 1'b0;
         near_ff      <= 1'b0;
         lc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) prev_ff[k] <= '0;
      end else begin
         // S_OUT reloads the output register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_action)
                     ACT_START: begin
                        first_ff  <= 1'b0;
                        cvalid_ff <= 1'b0;
                        near_ff   <= 1'b0;
                        lc_ff     <= '0;
                     end
                     ACT_UPDATE: begin
                        pos_ff[0] <= req_coord_x;
                        pos_ff[1] <= req_coord_y;
                        pos_ff[2] <= req_coord_z;
                        n_ff      <= n_sat;
                        if (!first_ff) begin
                           addr_ff  <= '0;
                           ret_ff   <= S_LEAD;
                           state_ff <= S_RDW;
                        end else begin
                           i_ff       <= win_start;
                           end_ff     <= win_end;
                           have_ff    <= 1'b0;
                           closest_ff <= '0;
                           state_ff   <= S_WIN;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_RDW: state_ff <= ret_ff;
            // distance: squares accumulated axis by axis, then the root
            S_DSUB: begin
               mag_ff   <= mag;
               state_ff <= S_DMUL;
            end
            S_DMUL: begin
               if (axis_ff == 2'd2) begin
                  rad_ff    <= acc_ff + prod;
                  sq_rem_ff <= '0;
                  root_ff   <= '0;
                  cnt_ff    <= '0;
                  state_ff  <= S_DSQ;
               end else begin
                  acc_ff   <= acc_ff + prod;
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= S_DSUB;
               end
            end
            S_DSQ: begin
               sq_rem_ff <= sq_take ? 26'(sq_r2 - sq_trial) : sq_r2[25:0];
               root_ff   <= {root_ff[23:0], sq_take};
               rad_ff    <= {rad_ff[47:0], 2'b00};
               cnt_ff    <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd24) state_ff <= dret_ff;
            end
            // lead-in toward the first waypoint
            S_LEAD: begin
               for (int k = 0; k < 3; k++) begin
                  op_a_ff[k] <= rd_ff[k*COORD_W +: COORD_W];
                  op_b_ff[k] <= pos_ff[k];
               end
               axis_ff  <= '0;
               acc_ff   <= '0;
               dret_ff  <= S_LEAD2;
               state_ff <= S_DSUB;
            end
            S_LEAD2: begin
               for (int k = 0; k < 3; k++) carrot_ff[k] <= op_a_ff[k];
               if (root_ff < {2'b00, reach_ff}) first_ff <= 1'b1;
               if (!cvalid_ff) begin
                  for (int k = 0; k < 3; k++) prev_ff[k] <= op_a_ff[k];
                  cvalid_ff <= 1'b1;
               end
               lc_ff    <= '0;
               done_ff  <= 1'b0;
               state_ff <= S_OUT;
            end
            // closest point search, earliest wins ties
            S_WIN: begin
               if (i_ff < end_ff) begin
                  addr_ff  <= i_ff[AW-1:0];
                  ret_ff   <= S_WIN2;
                  state_ff <= S_RDW;
               end else begin
                  lc_ff    <= closest_ff[AW-1:0];
                  j_ff     <= closest_ff;
                  rem_ff   <= lookahead_ff;
                  state_ff <= S_WALK;
               end
            end
            S_WIN2: begin
               for (int k = 0; k < 3; k++) begin
                  op_a_ff[k] <= pos_ff[k];
                  op_b_ff[k] <= rd_ff[k*COORD_W +: COORD_W];
               end
               axis_ff  <= '0;
               acc_ff   <= '0;
               dret_ff  <= S_WIN3;
               state_ff <= S_DSUB;
            end
            S_WIN3: begin
               if (!have_ff || root_ff < best_ff) begin
                  best_ff    <= root_ff;
                  closest_ff <= i_ff;
                  have_ff    <= 1'b1;
               end
               i_ff     <= i_ff + CW'(1);
               state_ff <= S_WIN;
            end
            // segment walk: start point in op_b, end point in op_a
            S_WALK: begin
               if (j_ff < n_ff - CW'(1)) begin
                  addr_ff  <= j_ff[AW-1:0];
                  ret_ff   <= S_WALK1;
                  state_ff <= S_RDW;
               end else begin
                  state_ff <= S_LAST;
               end
            end
            S_WALK1: begin
               for (int k = 0; k < 3; k++) op_b_ff[k] <= rd_ff[k*COORD_W +: COORD_W];
               addr_ff  <= AW'(j_ff + CW'(1));
               ret_ff   <= S_WALK2;
               state_ff <= S_RDW;
            end
            S_WALK2: begin
               for (int k = 0; k < 3; k++) op_a_ff[k] <= rd_ff[k*COORD_W +: COORD_W];
               axis_ff  <= '0;
               acc_ff   <= '0;
               dret_ff  <= S_WALK3;
               state_ff <= S_DSUB;
            end
            S_WALK3: begin
               if (root_ff >= {2'b00, rem_ff}) begin
                  axis_ff  <= '0;
                  state_ff <= S_ISUB;
               end else begin
                  rem_ff   <= rem_ff - root_ff[DIST_W-1:0];
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= S_WALK;
               end
            end
            // interpolation along the segment, one axis at a time
            S_ISUB: begin
               mag_ff   <= mag;
               neg_ff   <= diff[24];
               state_ff <= S_IMUL;
            end
            S_IMUL: begin
               drem_ff <= '0;
               cnt_ff  <= '0;
               if (root_ff == '0) begin
                  dnum_ff  <= '0;
                  state_ff <= S_IFIN;
               end else begin
                  dnum_ff  <= prod[47:0];
                  state_ff <= S_IDIV;
               end
            end
            S_IDIV: begin
               drem_ff  <= dv_take ? 25'(dv_t - dv_d) : dv_t[24:0];
               dnum_ff  <= {dnum_ff[46:0], dv_take};
               cnt_ff   <= cnt_ff + 6'd1;
               if (cnt_ff == 6'd47) state_ff <= S_IFIN;
            end
            S_IFIN: begin
               carrot_ff[axis_ff] <= interp[COORD_W-1:0];
               if (axis_ff == 2'd2) begin
                  state_ff <= S_JUMP;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= S_ISUB;
               end
            end
            // path ran out: last point
            S_LAST: begin
               addr_ff  <= AW'(n_ff - CW'(1));
               ret_ff   <= S_LAST2;
               state_ff <= S_RDW;
            end
            S_LAST2: begin
               for (int k = 0; k < 3; k++) carrot_ff[k] <= rd_ff[k*COORD_W +: COORD_W];
               state_ff <= S_JUMP;
            end
            // jump limit against the previous carrot
            S_JUMP: begin
               if (!cvalid_ff) begin
                  cvalid_ff <= 1'b1;
                  state_ff  <= S_FIN0;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     op_a_ff[k] <= carrot_ff[k];
                     op_b_ff[k] <= prev_ff[k];
                  end
                  axis_ff  <= '0;
                  acc_ff   <= '0;
                  dret_ff  <= S_JUMP2;
                  state_ff <= S_DSUB;
               end
            end
            S_JUMP2: begin
               if (root_ff > {2'b00, max_jump_ff}) begin
                  for (int k = 0; k < 3; k++) carrot_ff[k] <= prev_ff[k];
               end
               state_ff <= S_FIN0;
            end
            // near-end flag and finish test
            S_FIN0: begin
               for (int k = 0; k < 3; k++) prev_ff[k] <= carrot_ff[k];
               if (j_ff >= n_ff - CW'(2)) near_ff <= 1'b1;
               addr_ff  <= AW'(n_ff - CW'(1));
               ret_ff   <= S_FIN1;
               state_ff <= S_RDW;
            end
            S_FIN1: begin
               for (int k = 0; k < 3; k++) begin
                  op_a_ff[k] <= rd_ff[k*COORD_W +: COORD_W];
                  op_b_ff[k] <= pos_ff[k];
               end
               axis_ff  <= '0;
               acc_ff   <= '0;
               dret_ff  <= S_FIN2;
               state_ff <= S_DSUB;
            end
            S_FIN2: begin
               done_ff  <= near_ff && (root_ff < {2'b00, finish_ff});
               state_ff <= S_OUT;
            end
            // hand the item to the output register
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_x_ff      <= carrot_ff[0];
                  rsp_y_ff      <= carrot_ff[1];
                  rsp_z_ff      <= carrot_ff[2];
                  rsp_done_ff   <= done_ff;
                  rsp_follow_ff <= first_ff;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_carrot_x   = rsp_x_ff;
   assign rsp_carrot_y   = rsp_y_ff;
   assign rsp_carrot_z   = rsp_z_ff;
   assign rsp_layer_done = rsp_done_ff;
   assign rsp_following  = rsp_follow_ff;

endmodule

// File: sim/tb_top.sv
// Testbench for the carrot lookahead point generator, checked against a built-in predictor.
`timescale 1ns / 100ps

module tb_top;
   import clp_pkg::*;

   // action code the block ignores
   localparam logic [1:0] ACT_IDLE = 2'd3;
   localparam int NUM_SLOTS = MAX_POINTS_DEF;
   localparam int ITEM_GOAL = 1500;

   typedef struct packed {
      longint x;
      longint y;
      longint z;
   } point_t;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      done;
      logic                      following;
   } carrot_exp_t;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_action;
   logic [INDEX_W-1:0] req_point_index;
   logic signed [COORD_W-1:0] req_coord_x, req_coord_y, req_coord_z;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [COORD_W-1:0] rsp_carrot_x, rsp_carrot_y, rsp_carrot_z;
   logic rsp_layer_done;
   logic rsp_following;
   logic csr_we;
   logic [2:0] csr_index;
   logic [DIST_W-1:0] csr_wdata;

   carrot_lookahead_point dut (.*);

   // predictor state
   point_t waypoints [NUM_SLOTS];
   bit first_reached, carrot_live, tail_reached;
   point_t held_target;
   int unsigned last_closest;
   longint unsigned cfg_lookahead, cfg_max_jump, cfg_count, cfg_reach, cfg_finish;

   carrot_exp_t expected_carrots [$];
   int error_count = 0;
   int sent_items = 0;
   int update_count = 0;
   int checked_count = 0;
   int done_seen = 0;
   int burst_left = 0;
   int stall_left = 0;
   int stall_mode = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------- predictor ----------------
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else
            r = r >> 1;
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned point_gap(point_t a, point_t b);
      longint d;
      longint unsigned s;
      s = 0;
      d = a.x - b.x; if (d < 0) d = -d; s += d * d;
      d = a.y - b.y; if (d < 0) d = -d; s += d * d;
      d = a.z - b.z; if (d < 0) d = -d; s += d * d;
      return int_sqrt(s);
   endfunction

   function automatic longint floor_quot(longint num, longint den);
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
   endfunction

   function automatic longint lerp_axis(longint a, longint b, longint unsigned rem,
                                        longint unsigned seg);
      if (seg == 0) return a;
      return a + floor_quot(longint'(rem) * (b - a), longint'(seg));
   endfunction

   function automatic carrot_exp_t predict_update(point_t pos);
      int unsigned n, lo, hi, i, j, nearest;
      longint unsigned best, d, rem, seg;
      bit have, done;
      point_t carrot;
      carrot_exp_t r;
      n = 32'(cfg_count);
      if (n < 2) n = 2;
      if (n > NUM_SLOTS) n = NUM_SLOTS;
      done = 1'b0;
      if (!first_reached) begin
         // lead-in: steer at the first waypoint
         carrot = waypoints[0];
         if (point_gap(carrot, pos) < cfg_reach) first_reached = 1'b1;
         if (!carrot_live) begin
            held_target = carrot;
            carrot_live = 1'b1;
         end
         last_closest = 0;
      end else begin
         // closest point in the search window, earliest wins ties
         lo = (last_closest > BACK_WINDOW_DEF) ? last_closest - BACK_WINDOW_DEF : 0;
         hi = last_closest + AHEAD_WINDOW_DEF;
         if (hi > n - 1) hi = n - 1;
         nearest = 0;
         have = 1'b0;
         best = 0;
         for (i = lo; i < hi; i++) begin
            d = point_gap(pos, waypoints[i]);
            if (!have || d < best) begin
               best = d;
               nearest = i;
               have = 1'b1;
            end
         end
         last_closest = nearest;
         // walk the arc length forward
         rem = cfg_lookahead;
         j = nearest;
         while (j < n - 1) begin
            seg = point_gap(waypoints[j + 1], waypoints[j]);
            if (seg >= rem) begin
               carrot.x = lerp_axis(waypoints[j].x, waypoints[j + 1].x, rem, seg);
               carrot.y = lerp_axis(waypoints[j].y, waypoints[j + 1].y, rem, seg);
               carrot.z = lerp_axis(waypoints[j].z, waypoints[j + 1].z, rem, seg);
               break;
            end
            rem -= seg;
            j++;
         end
         if (j >= n - 1) carrot = waypoints[n - 1];
         // jump limit
         if (!carrot_live)
            carrot_live = 1'b1;
         else if (point_gap(carrot, held_target) > cfg_max_jump)
            carrot = held_target;
         held_target = carrot;
         if (j >= n - 2) tail_reached = 1'b1;
         done = tail_reached && (point_gap(waypoints[n - 1], pos) < cfg_finish);
      end
      r.x = carrot.x[COORD_W-1:0];
      r.y = carrot.y[COORD_W-1:0];
      r.z = carrot.z[COORD_W-1:0];
      r.done = done;
      r.following = first_reached;
      return r;
   endfunction

   function automatic void apply_item(logic [1:0] act, logic [INDEX_W-1:0] idx, point_t p);
      case (act)
         ACT_LOAD: waypoints[idx] = p;
         ACT_START: begin
            first_reached = 1'b0;
            carrot_live = 1'b0;
            tail_reached = 1'b0;
            last_closest = 0;
         end
         ACT_UPDATE: begin
            expected_carrots.insert(expected_carrots.size(), predict_update(p));
            update_count++;
         end
         default: ;
      endcase
      if (act != ACT_IDLE) sent_items++;
   endfunction

   // ---------------- result checking ----------------
   task automatic note_mismatch(string msg);
      error_count++;
      if (error_count <= 30) $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin : result_check
      carrot_exp_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_carrots.size() == 0)
            note_mismatch("result with no update waiting");
         else begin
            e = expected_carrots.pop_front();
            checked_count++;
            if (rsp_layer_done) done_seen++;
            if (rsp_carrot_x !== e.x)
               note_mismatch($sformatf("carrot_x %0d exp %0d", rsp_carrot_x, e.x));
            if (rsp_carrot_y !== e.y)
               note_mismatch($sformatf("carrot_y %0d exp %0d", rsp_carrot_y, e.y));
            if (rsp_carrot_z !== e.z)
               note_mismatch($sformatf("carrot_z %0d exp %0d", rsp_carrot_z, e.z));
            if (rsp_layer_done !== e.done)
               note_mismatch($sformatf("layer_done %0b exp %0b", rsp_layer_done, e.done));
            if (rsp_following !== e.following)
               note_mismatch($sformatf("following %0b exp %0b", rsp_following, e.following));
         end
      end
   end

   // receiver stall pattern: free-running, random, or mostly stalled stretches
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 1) == 1);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // ---------------- stimulus helpers ----------------
   function automatic longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic point_t make_point(longint x, longint y, longint z);
      point_t p;
      p.x = clamp24(x);
      p.y = clamp24(y);
      p.z = clamp24(z);
      return p;
   endfunction

   function automatic point_t rand_point();
      logic signed [COORD_W-1:0] t;
      point_t p;
      t = COORD_W'($urandom); p.x = t;
      t = COORD_W'($urandom); p.y = t;
      t = COORD_W'($urandom); p.z = t;
      return p;
   endfunction

   function automatic longint jitter(int amp);
      return longint'($urandom_range(0, 2 * amp)) - amp;
   endfunction

   function automatic point_t near_point(point_t c, int amp);
      return make_point(c.x + jitter(amp), c.y + jitter(amp), c.z + jitter(amp));
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(logic [1:0] act, logic [INDEX_W-1:0] idx, point_t p);
      int gap;
      if (burst_left <= 0) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, 25);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_valid = 1'b1;
      req_action = act;
      req_point_index = idx;
      req_coord_x = p.x[COORD_W-1:0];
      req_coord_y = p.y[COORD_W-1:0];
      req_coord_z = p.z[COORD_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_item(act, idx, p);
      burst_left--;
      @(negedge clock);
   endtask

   // hold off until every expected result is in and the block has settled
   task automatic drain_results();
      req_valid = 1'b0;
      while (expected_carrots.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, longint unsigned v);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = v[DIST_W-1:0];
      case (idx)
         CSR_LOOKAHEAD: cfg_lookahead = 64'(v[DIST_W-1:0]);
         CSR_MAX_JUMP:  cfg_max_jump = 64'(v[DIST_W-1:0]);
         CSR_COUNT:     cfg_count = 64'(v[COUNT_W-1:0]);
         CSR_REACH:     cfg_reach = 64'(v[DIST_W-1:0]);
         CSR_FINISH:    cfg_finish = 64'(v[DIST_W-1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_layer(longint unsigned la, longint unsigned mj, longint unsigned cnt,
                            longint unsigned rr, longint unsigned fr);
      drain_results();
      write_reg(CSR_LOOKAHEAD, la);
      write_reg(CSR_MAX_JUMP, mj);
      write_reg(CSR_COUNT, cnt);
      write_reg(CSR_REACH, rr);
      write_reg(CSR_FINISH, fr);
   endtask

   // ---------------- tests ----------------
   // fill every slot so nothing unwritten is ever read, then run on the defaults
   task automatic test_defaults();
      point_t p;
      for (int i = 0; i < NUM_SLOTS; i++) send_item(ACT_LOAD, i[INDEX_W-1:0], rand_point());
      p = make_point(0, 0, 0);
      waypoints[0] = waypoints[0];
      send_item(ACT_LOAD, 8'd1, make_point(30000, 0, 0));
      send_item(ACT_LOAD, 8'd0, p);
      send_item(ACT_START, 8'd0, p);
      send_item(ACT_UPDATE, 8'd0, make_point(100000, 0, 0));
      send_item(ACT_UPDATE, 8'd0, make_point(1000, 1000, 0));
      send_item(ACT_UPDATE, 8'd0, make_point(15000, 0, 0));
      send_item(ACT_UPDATE, 8'd0, make_point(29000, 0, 0));
   endtask

   // coordinate and register extremes on a two point layer
   task automatic test_extremes();
      point_t hi, lo;
      hi = make_point(8388607, 8388607, 8388607);
      lo = make_point(-8388608, -8388608, -8388608);
      set_layer(1, 8388607, 2, 8388607, 0);
      send_item(ACT_LOAD, 8'd0, hi);
      send_item(ACT_LOAD, 8'd1, lo);
      send_item(ACT_START, 8'd0, hi);
      send_item(ACT_UPDATE, 8'd0, lo);
      send_item(ACT_UPDATE, 8'd0, hi);
      send_item(ACT_UPDATE, 8'd0, make_point(0, 0, 0));
      set_layer(8388607, 0, 2, 0, 8388607);
      send_item(ACT_UPDATE, 8'd0, lo);
      send_item(ACT_START, 8'd0, lo);
      send_item(ACT_UPDATE, 8'd0, hi);
      set_layer(8388607, 0, 2, 8388607, 8388607);
      send_item(ACT_START, 8'd0, lo);
      send_item(ACT_UPDATE, 8'd0, hi);
      send_item(ACT_UPDATE, 8'd0, lo);
   endtask

   // ignored action and restart in the middle of following
   task automatic test_ignored_and_restart();
      set_layer(40000, 100000, 4, 20000, 20000);
      send_item(ACT_LOAD, 8'd0, make_point(0, 0, 0));
      send_item(ACT_LOAD, 8'd1, make_point(0, 0, 0));
      send_item(ACT_LOAD, 8'd2, make_point(50000, 0, 0));
      send_item(ACT_LOAD, 8'd3, make_point(50000, 50000, 0));
      send_item(ACT_START, 8'd0, make_point(0, 0, 0));
      send_item(ACT_UPDATE, 8'd0, make_point(0, 0, 0));
      send_item(ACT_IDLE, 8'd255, make_point(-1, -1, -1));
      send_item(ACT_UPDATE, 8'd0, make_point(40000, 0, 0));
      send_item(ACT_START, 8'd0, make_point(0, 0, 0));
      send_item(ACT_UPDATE, 8'd0, make_point(50000, 50000, 0));
   endtask

   // point_count below and above its range is used saturated
   task automatic test_count_saturation();
      set_layer(60000, 8388607, 0, 8388607, 30000);
      send_item(ACT_START, 8'd0, make_point(0, 0, 0));
      send_item(ACT_UPDATE, 8'd0, make_point(0, 0, 0));
      send_item(ACT_UPDATE, 8'd0, make_point(10, 0, 0));
      set_layer(60000, 8388607, 1, 8388607, 30000);
      send_item(ACT_UPDATE, 8'd0, make_point(0, 20, 0));
      set_layer(8388607, 8388607, 511, 8388607, 8388607);
      send_item(ACT_START, 8'd0, make_point(0, 0, 0));
      send_item(ACT_UPDATE, 8'd0, make_point(0, 0, 0));
      send_item(ACT_UPDATE, 8'd0, make_point(3, 0, 0));
      set_layer(1, 8388607, 256, 8388607, 8388607);
      send_item(ACT_UPDATE, 8'd0, make_point(0, 0, 0));
   endtask

   // random layers: load a path, start, then fly along it with noise mixed in
   task automatic test_random_layers();
      int n, loaded, step, amp, pick, layer_no;
      longint unsigned la, mj, rr, fr;
      point_t p, cur;
      layer_no = 0;
      while (sent_items < ITEM_GOAL) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) n = $urandom_range(2, 24);
         else if (pick < 96) n = $urandom_range(25, 80);
         else n = NUM_SLOTS;
         step = $urandom_range(500, 60000);
         la = 64'($urandom_range(1, step * 4));
         if ($urandom_range(0, 19) == 0) la = 8388607;
         if ($urandom_range(0, 3) == 0) mj = 64'($urandom_range(0, step));
         else mj = 64'(step * 10);
         rr = 64'($urandom_range(0, step * 2));
         fr = 64'($urandom_range(0, step * 2));
         set_layer(la, mj, 64'(n), rr, fr);
         loaded = (n > 40) ? 40 : n;
         cur = near_point(make_point(0, 0, 0), 6000000);
         for (int i = 0; i < loaded; i++) begin
            // occasional repeated point gives a zero-length segment
            if (i > 0 && $urandom_range(0, 9) != 0) cur = near_point(cur, step);
            send_item(ACT_LOAD, i[INDEX_W-1:0], cur);
         end
         send_item(ACT_START, 8'd0, cur);
         send_item(ACT_UPDATE, 8'd0, near_point(waypoints[0], step * 8));
         send_item(ACT_UPDATE, 8'd0, near_point(waypoints[0], step / 4 + 1));
         amp = $urandom_range(0, step);
         for (int i = 0; i < loaded + 4; i++) begin
            pick = $urandom_range(0, 99);
            p = near_point(waypoints[(i < loaded) ? i : loaded - 1], amp);
            if (pick < 85) send_item(ACT_UPDATE, 8'd0, p);
            else if (pick < 90) send_item(ACT_IDLE, INDEX_W'($urandom), rand_point());
            else if (pick < 95) send_item(ACT_UPDATE, 8'd0, rand_point());
            else if (pick < 98)
               send_item(ACT_LOAD, INDEX_W'($urandom_range(loaded, NUM_SLOTS - 1)),
                         rand_point());
            else send_item(ACT_START, 8'd0, p);
         end
         if (layer_no == 0 || $urandom_range(0, 7) == 0) drain_results();
         layer_no++;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_LOAD;
      req_point_index = '0;
      req_coord_x = '0;
      req_coord_y = '0;
      req_coord_z = '0;
      csr_we = 1'b0;
      csr_index = CSR_LOOKAHEAD;
      csr_wdata = '0;
      first_reached = 1'b0;
      carrot_live = 1'b0;
      tail_reached = 1'b0;
      held_target = '0;
      last_closest = 0;
      cfg_lookahead = LOOKAHEAD_RST;
      cfg_max_jump = MAX_JUMP_RST;
      cfg_count = COUNT_RST;
      cfg_reach = REACH_RST;
      cfg_finish = FINISH_RST;
      for (int i = 0; i < NUM_SLOTS; i++) waypoints[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_defaults();
      test_extremes();
      test_ignored_and_restart();
      test_count_saturation();
      test_random_layers();

      drain_results();
      repeat (50) @(negedge clock);
      $display("Run covered %0d accepted items, %0d position updates, %0d results checked",
               sent_items, update_count, checked_count);
      $display("Layers completed in %0d results; %0d mismatches", done_seen, error_count);
      if (error_count == 0 && expected_carrots.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
